>>> hw/rtl/spm_pkg.sv
// Shared types and constants of the sparse polynomial add/multiply block.
// Holds the request and result item structs, op codes and register map.
// No dependencies.
package spm_pkg;

    localparam int MAX_DEGREE_DEF = 31;
    localparam int COEF_WIDTH_DEF = 32;

    localparam int IN_COEF_W  = 32;
    localparam int IN_DEG_W   = 5;
    localparam int RES_COEF_W = 32;
    localparam int RES_DEG_W  = 6;

    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    typedef enum logic [1:0] {
        OP_LOAD_FIRST  = 2'd0,
        OP_LOAD_SECOND = 2'd1,
        OP_FINISH      = 2'd2
    } t_op;

    typedef enum logic [PADDR_W-3:0] {
        REG_OPERATION_MODE = 1'b0
    } t_reg_idx;

    typedef struct packed {
        logic [1:0]                  op;
        logic signed [IN_COEF_W-1:0] coefficient;
        logic [IN_DEG_W-1:0]         degree;
    } t_in_item;

    typedef struct packed {
        logic signed [RES_COEF_W-1:0] result_coefficient;
        logic [RES_DEG_W-1:0]         result_degree;
        logic                         term_valid;
        logic                         last;
    } t_out_item;

    // Per-cycle control shared by the feeder and every cell.
    typedef struct packed {
        logic en;
        logic mode;
        logic clear;
    } t_step_ctl;

endpackage

>>> hw/rtl/spm_cell.sv
// One cell of the product chain: holds one term of the first polynomial.
// Depends on spm_pkg for the step control struct.
module spm_cell
    import spm_pkg::*;
#(
    parameter int DATA_W  = 32,
    parameter bit IS_UNIT = 1'b0
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_step_ctl         i_ctl,
    input  logic              i_load,
    input  logic [DATA_W-1:0] i_coef,
    input  logic [DATA_W-1:0] i_x,
    input  logic              i_xp,
    input  logic [DATA_W-1:0] i_sum,
    input  logic              i_have,
    output logic [DATA_W-1:0] o_sum,
    output logic              o_have,
    output logic [DATA_W-1:0] o_coef,
    output logic              o_present
);

    logic [DATA_W-1:0] r_coef;
    logic              r_present;
    logic [DATA_W-1:0] r_prod;
    logic              r_pp;
    logic [DATA_W-1:0] r_sum;
    logic              r_have;

    logic [DATA_W-1:0] w_h;
    logic              w_hp;
    logic [DATA_W-1:0] w_mul;

    // In add mode the degree-zero cell acts as the constant polynomial one.
    assign w_h   = i_ctl.mode ? r_coef : DATA_W'(IS_UNIT);
    assign w_hp  = i_ctl.mode ? r_present : IS_UNIT;
    assign w_mul = w_h * i_x;

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_coef <= i_coef;
        end
        if (i_ctl.en) begin
            r_prod <= w_mul;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_present <= 1'b0;
            r_pp      <= 1'b0;
            r_sum     <= '0;
            r_have    <= 1'b0;
        end else begin
            if (i_ctl.clear) begin
                r_present <= 1'b0;
            end else if (i_load) begin
                r_present <= 1'b1;
            end
            if (i_ctl.en) begin
                r_pp   <= w_hp & i_xp;
                r_sum  <= (r_pp ? r_prod : '0) + i_sum;
                r_have <= r_pp | i_have;
            end
        end
    end

    assign o_sum     = r_sum;
    assign o_have    = r_have;
    assign o_coef    = r_coef;
    assign o_present = r_present;

endmodule

>>> hw/rtl/spm_feed.sv
// Stream feeder: second polynomial store and the two-stage read pipe that
// forms the value broadcast to the cell chain. Depends on spm_pkg.
module spm_feed
    import spm_pkg::*;
#(
    parameter int DATA_W = 32,
    parameter int DEPTH  = 32,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_step_ctl         i_ctl,
    input  logic              i_wr,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [DATA_W-1:0] i_wr_data,
    input  logic              i_rd,
    input  logic [ADDR_W-1:0] i_rd_addr,
    input  logic [DATA_W-1:0] i_a_coef [DEPTH],
    input  logic [DEPTH-1:0]  i_a_pres,
    output logic [DATA_W-1:0] o_x,
    output logic              o_xp
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DEPTH-1:0]  r_b_pres;

    logic [DATA_W-1:0] r_a;
    logic [DATA_W-1:0] r_b;
    logic              r_ap;
    logic              r_bp;
    logic [DATA_W-1:0] r_x;
    logic              r_xp;

    logic [DATA_W-1:0] w_ga;
    logic [DATA_W-1:0] w_gb;

    assign w_ga = r_ap ? r_a : '0;
    assign w_gb = r_bp ? r_b : '0;

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            mem[i_wr_addr] <= i_wr_data;
        end
        if (i_ctl.en) begin
            r_b <= mem[i_rd_addr];
            r_a <= i_a_coef[i_rd_addr];
            r_x <= i_ctl.mode ? w_gb : w_ga + w_gb;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_pres <= '0;
            r_ap     <= 1'b0;
            r_bp     <= 1'b0;
            r_xp     <= 1'b0;
        end else begin
            if (i_ctl.clear) begin
                r_b_pres <= '0;
            end else if (i_wr) begin
                r_b_pres[i_wr_addr] <= 1'b1;
            end
            if (i_ctl.en) begin
                r_ap <= i_rd & i_a_pres[i_rd_addr];
                r_bp <= i_rd & r_b_pres[i_rd_addr];
                r_xp <= i_ctl.mode ? r_bp : (r_ap | r_bp);
            end
        end
    end

    assign o_x  = r_x;
    assign o_xp = r_xp;

endmodule

>>> hw/rtl/sparse_polynomial_add_multiply.sv
// Sparse polynomial adder/multiplier, top level: request handshake, mode
// register, cell chain and result sequencer. Uses spm_pkg, spm_feed, spm_cell.
// A finish request delivers its last result after the feeder pipe, one chain step per
// result degree and one flush. Throughput: one load request per cycle while no run is
// in progress; a finish blocks requests until its run ends, and result stalls lengthen
// the run. Reset (synchronous, active low) clears presence bits, mode and handshakes.
module sparse_polynomial_add_multiply
    import spm_pkg::*;
#(
    parameter int MAX_DEGREE = MAX_DEGREE_DEF,
    parameter int COEF_WIDTH = COEF_WIDTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  t_in_item           i_in,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output t_out_item          o_out,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    // Only the low result bits are visible, so the datapath never needs to
    // be wider than the result coefficient.
    localparam int DEPTH    = MAX_DEGREE + 1;
    localparam int AW       = (COEF_WIDTH < RES_COEF_W) ? COEF_WIDTH : RES_COEF_W;
    localparam int ADDR_W   = $clog2(DEPTH);
    localparam int PIPE_LAT = 4;
    localparam int CNT_W    = $clog2(2 * MAX_DEGREE + PIPE_LAT + 2);

    localparam logic [CNT_W-1:0] CNT_FEED_END = CNT_W'(MAX_DEGREE);
    localparam logic [CNT_W-1:0] CNT_TAKE_LO  = CNT_W'(PIPE_LAT);
    localparam logic [CNT_W-1:0] CNT_TAKE_HI  = CNT_W'(2 * MAX_DEGREE + PIPE_LAT);
    localparam logic [CNT_W-1:0] CNT_LAST     = CNT_W'(2 * MAX_DEGREE + PIPE_LAT + 1);

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } t_state;

    t_state                r_state, n_state;
    logic [CNT_W-1:0]      r_cnt, n_cnt;
    logic                  r_pend_v, n_pend_v;
    logic [RES_COEF_W-1:0] r_pend_coef, n_pend_coef;
    logic [RES_DEG_W-1:0]  r_pend_deg, n_pend_deg;
    t_out_item             r_out, n_out;
    logic                  r_out_valid, n_out_valid;
    logic                  r_mode;

    logic            w_en;
    logic            w_in_acc;
    logic            w_load_ok;
    logic            w_load_first;
    logic            w_load_second;
    logic            w_start;
    logic            w_step;
    logic            w_take;
    logic            w_clear;
    logic            w_rd;
    logic [ADDR_W-1:0] w_rd_addr;
    logic [ADDR_W-1:0] w_wr_addr;
    logic [AW-1:0]     w_wr_data;
    logic [RES_DEG_W-1:0] w_deg;
    t_step_ctl       w_ctl;
    logic            w_cfg_wr;

    logic [AW-1:0]    w_a_coef [DEPTH];
    logic [DEPTH-1:0] w_a_pres;
    logic [AW-1:0]    w_sum [DEPTH];
    logic [DEPTH-1:0] w_have;
    logic [AW-1:0]    w_x;
    logic             w_xp;

    // The whole chain moves one step only when the output register can take
    // a result, so a stall on the result side freezes every stage together.
    assign w_en = !r_out_valid || i_out_ready;

    assign o_in_ready    = (r_state == ST_IDLE);
    assign w_in_acc      = i_in_valid && o_in_ready;
    // Loads above the supported degree are dropped without any effect.
    assign w_load_ok     = w_in_acc && (i_in.degree <= IN_DEG_W'(MAX_DEGREE));
    assign w_load_first  = w_load_ok && (i_in.op == OP_LOAD_FIRST);
    assign w_load_second = w_load_ok && (i_in.op == OP_LOAD_SECOND);
    assign w_start       = w_in_acc && (i_in.op == OP_FINISH);
    assign w_wr_addr     = ADDR_W'(i_in.degree);
    assign w_wr_data     = AW'(i_in.coefficient);

    // Counter timeline of a run: the second operand (both summed in add mode)
    // is streamed in descending degree during the first DEPTH steps, the chain
    // output holds result degree 2*MAX_DEGREE+PIPE_LAT-count from step PIPE_LAT
    // on, and the final step flushes the held term with its last marker.
    assign w_step    = (r_state == ST_RUN) && w_en;
    assign w_rd      = (r_state == ST_RUN) && (r_cnt <= CNT_FEED_END);
    assign w_rd_addr = ADDR_W'(CNT_FEED_END - r_cnt);
    assign w_take    = w_step && (r_cnt >= CNT_TAKE_LO) && (r_cnt <= CNT_TAKE_HI);
    assign w_clear   = w_step && (r_cnt == CNT_LAST);
    assign w_deg     = RES_DEG_W'(CNT_TAKE_HI - r_cnt);

    assign w_ctl.en    = w_en;
    assign w_ctl.mode  = r_mode;
    assign w_ctl.clear = w_clear;

    spm_feed #(
        .DATA_W (AW),
        .DEPTH  (DEPTH)
    ) u_feed (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (w_ctl),
        .i_wr      (w_load_second),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd      (w_rd),
        .i_rd_addr (w_rd_addr),
        .i_a_coef  (w_a_coef),
        .i_a_pres  (w_a_pres),
        .o_x       (w_x),
        .o_xp      (w_xp)
    );

    // Cell k holds degree k of the first operand. Partial sums travel from
    // the degree-zero cell upwards and leave the chain at the top cell, which
    // gives the transposed form of the convolution with the stream.
    for (genvar k = 0; k < DEPTH; k++) begin : g_cell
        logic [AW-1:0] w_sum_in;
        logic          w_have_in;
        logic          w_load;

        if (k == 0) begin : g_head
            assign w_sum_in  = '0;
            assign w_have_in = 1'b0;
        end else begin : g_link
            assign w_sum_in  = w_sum[k-1];
            assign w_have_in = w_have[k-1];
        end

        assign w_load = w_load_first && (i_in.degree == IN_DEG_W'(k));

        spm_cell #(
            .DATA_W  (AW),
            .IS_UNIT (k == 0)
        ) u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_ctl     (w_ctl),
            .i_load    (w_load),
            .i_coef    (w_wr_data),
            .i_x       (w_x),
            .i_xp      (w_xp),
            .i_sum     (w_sum_in),
            .i_have    (w_have_in),
            .o_sum     (w_sum[k]),
            .o_have    (w_have[k]),
            .o_coef    (w_a_coef[k]),
            .o_present (w_a_pres[k])
        );
    end

    // A result term is held back one place so that the last marker can be
    // attached once it is known that no later degree exists.
    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_pend_v    = r_pend_v;
        n_pend_coef = r_pend_coef;
        n_pend_deg  = r_pend_deg;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_out_ready;
        case (r_state)
            ST_IDLE: begin
                if (w_start) begin
                    n_state  = ST_RUN;
                    n_cnt    = '0;
                    n_pend_v = 1'b0;
                end
            end
            ST_RUN: begin
                if (w_en) begin
                    n_cnt = r_cnt + CNT_W'(1);
                    if (w_take && w_have[DEPTH-1]) begin
                        if (r_pend_v) begin
                            n_out.result_coefficient = r_pend_coef;
                            n_out.result_degree      = r_pend_deg;
                            n_out.term_valid         = 1'b1;
                            n_out.last               = 1'b0;
                            n_out_valid              = 1'b1;
                        end
                        n_pend_v    = 1'b1;
                        n_pend_coef = RES_COEF_W'(w_sum[DEPTH-1]);
                        n_pend_deg  = w_deg;
                    end
                    if (r_cnt == CNT_LAST) begin
                        n_state     = ST_IDLE;
                        n_out_valid = 1'b1;
                        n_out.last  = 1'b1;
                        if (r_pend_v) begin
                            n_out.result_coefficient = r_pend_coef;
                            n_out.result_degree      = r_pend_deg;
                            n_out.term_valid         = 1'b1;
                        end else begin
                            // Empty result: one item that carries no term.
                            n_out.result_coefficient = '0;
                            n_out.result_degree      = '0;
                            n_out.term_valid         = 1'b0;
                        end
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_pend_v    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_pend_v    <= n_pend_v;
            r_out_valid <= n_out_valid;
        end
        r_pend_coef <= n_pend_coef;
        r_pend_deg  <= n_pend_deg;
        r_out       <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // Configuration port: a single mode bit, written in the access phase.
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= 1'b0;
        end else if (w_cfg_wr) begin
            case (paddr[PADDR_W-1:2])
                REG_OPERATION_MODE: r_mode <= pwdata[0];
                default:            r_mode <= r_mode;
            endcase
        end
    end

    always_comb begin
        case (paddr[PADDR_W-1:2])
            REG_OPERATION_MODE: prdata = PDATA_W'(r_mode);
            default:            prdata = '0;
        endcase
    end

    // Only the closing item of a run may lack a term.
    a_empty_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out.term_valid) |-> o_out.last)
        else $error("result item without a term is not the final item");

    // Terms leave the chain in strictly falling degree.
    a_degree_falls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_take && w_have[DEPTH-1] && r_pend_v) |-> (r_pend_deg > w_deg))
        else $error("result degrees do not fall");

    // The closing step leaves the first operand empty.
    a_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_clear |=> (w_a_pres == '0))
        else $error("presence bits survive the end of a run");

    // A stall on the result side freezes the run sequencer.
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RUN && !w_en) |=> $stable(r_cnt))
        else $error("run counter moved during a result stall");

endmodule

>>> tb/sparse_polynomial_add_multiply_tb.sv
// Self-checking testbench for the sparse polynomial add/multiply block.
// It predicts every result term from its own model of the two term stores.
// Depends on spm_pkg and the sparse_polynomial_add_multiply top level.
module sparse_polynomial_add_multiply_tb;
    import spm_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Op code 3 has no meaning in the package; the block must ignore it.
    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int STORE_DEPTH = MAX_DEGREE_DEF + 1;
    localparam int PRODUCT_DEPTH = 2 * MAX_DEGREE_DEF + 1;
    // Time from a finish request to its last term, plus some margin.
    localparam int DRAIN_CYCLES = 2 * MAX_DEGREE_DEF + 6 + 16;
    localparam int RANDOM_REQUESTS = 120;

    // A pending entry is either a request for the sender or a hold, which
    // makes the sender wait until every predicted term has come back.
    typedef struct {
        logic     hold;
        t_in_item req;
    } t_pending;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_ready;
    t_in_item           i_in;
    logic               o_out_valid;
    logic               i_out_ready;
    t_out_item          o_out;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    sparse_polynomial_add_multiply i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    // Shadow copy of the block's state; the term predictor keeps the stores, write_register the mode.
    logic [31:0] first_coef    [STORE_DEPTH];
    logic        first_present [STORE_DEPTH];
    logic [31:0] second_coef   [STORE_DEPTH];
    logic        second_present[STORE_DEPTH];
    logic        mode_mirror;

    t_pending  pending_requests[$];
    t_out_item expected_terms[$];

    int  mismatches;
    int  random_requests;
    int  in_gap;
    int  out_stall;
    bit  quiet;
    bit  full_done;

    initial begin
        i_clk = 1'b0;
    end

    always #5 i_clk = ~i_clk;

    // The term predictor: applies one accepted request to the shadow stores
    // and, for a finish, queues the terms that the block ought to emit.
    function automatic void predict_terms(input t_in_item req);
        logic [31:0] acc [PRODUCT_DEPTH];
        logic        have[PRODUCT_DEPTH];
        t_out_item   term;
        int          found;

        case (req.op)
            OP_LOAD_FIRST: begin
                first_coef[req.degree]    = req.coefficient;
                first_present[req.degree] = 1'b1;
            end
            OP_LOAD_SECOND: begin
                second_coef[req.degree]    = req.coefficient;
                second_present[req.degree] = 1'b1;
            end
            OP_FINISH: begin
                found = 0;
                for (int d = 0; d < PRODUCT_DEPTH; d++) begin
                    acc[d]  = '0;
                    have[d] = 1'b0;
                end
                for (int i = 0; i < STORE_DEPTH; i++) begin
                    if (mode_mirror) begin
                        for (int j = 0; j < STORE_DEPTH; j++) begin
                            if (first_present[i] && second_present[j]) begin
                                acc[i+j]  = acc[i+j] + first_coef[i] * second_coef[j];
                                have[i+j] = 1'b1;
                            end
                        end
                    end else begin
                        if (first_present[i]) begin
                            acc[i]  = acc[i] + first_coef[i];
                            have[i] = 1'b1;
                        end
                        if (second_present[i]) begin
                            acc[i]  = acc[i] + second_coef[i];
                            have[i] = 1'b1;
                        end
                    end
                end
                // Terms leave in descending degree, cancelled ones included.
                for (int d = PRODUCT_DEPTH - 1; d >= 0; d--) begin
                    if (have[d]) begin
                        term.result_coefficient = acc[d];
                        term.result_degree      = d[RES_DEG_W-1:0];
                        term.term_valid         = 1'b1;
                        term.last               = 1'b0;
                        expected_terms.push_back(term);
                        found++;
                    end
                end
                if (found == 0) begin
                    // An empty result is a single marker with no term in it.
                    term = '{result_coefficient: '0, result_degree: '0,
                             term_valid: 1'b0, last: 1'b1};
                    expected_terms.push_back(term);
                end else begin
                    expected_terms[expected_terms.size()-1].last = 1'b1;
                end
                for (int i = 0; i < STORE_DEPTH; i++) begin
                    first_present[i]  = 1'b0;
                    second_present[i] = 1'b0;
                end
            end
            default: begin
                // The unused op code changes nothing.
            end
        endcase
    endfunction

    // Sender. A request that has been offered stays on the bus until it is
    // accepted; only then may a gap or the next request follow.
    always @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            predict_terms(i_in);
        end
        if (!i_in_valid || o_in_ready) begin
            if (in_gap > 0) begin
                in_gap--;
                i_in_valid <= 1'b0;
            end else if (pending_requests.size() > 0 && pending_requests[0].hold) begin
                // Hold the sender off until every predicted term has arrived.
                if (expected_terms.size() == 0) begin
                    void'(pending_requests.pop_front());
                end
                i_in_valid <= 1'b0;
            end else if (pending_requests.size() > 0) begin
                i_in_valid <= 1'b1;
                i_in       <= pending_requests[0].req;
                void'(pending_requests.pop_front());
                if (!quiet && $urandom_range(0, 6) == 0) begin
                    in_gap = $urandom_range(1, 10);
                end
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Receiver: checks every accepted term against the oldest prediction and
    // stalls the output side in random bursts unless quiet is set.
    always @(posedge i_clk) begin
        if (o_out_valid && i_out_ready) begin
            if (expected_terms.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("unexpected term: coef %0d degree %0d valid %0b last %0b",
                             o_out.result_coefficient, o_out.result_degree,
                             o_out.term_valid, o_out.last);
                end
            end else if (o_out.result_coefficient !== expected_terms[0].result_coefficient
                         || o_out.result_degree !== expected_terms[0].result_degree
                         || o_out.term_valid !== expected_terms[0].term_valid
                         || o_out.last !== expected_terms[0].last) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("term mismatch: expected coef %0d degree %0d valid %0b last %0b",
                             expected_terms[0].result_coefficient,
                             expected_terms[0].result_degree,
                             expected_terms[0].term_valid, expected_terms[0].last);
                    $display("               actual   coef %0d degree %0d valid %0b last %0b",
                             o_out.result_coefficient, o_out.result_degree,
                             o_out.term_valid, o_out.last);
                end
                void'(expected_terms.pop_front());
            end else begin
                void'(expected_terms.pop_front());
            end
        end
        if (quiet) begin
            i_out_ready <= 1'b1;
        end else if (out_stall > 0) begin
            out_stall--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
            if ($urandom_range(0, 9) == 0) begin
                out_stall = $urandom_range(1, 10);
            end
        end
    end

    task automatic push_request(input logic [1:0] op, input logic [31:0] coef,
                                input logic [IN_DEG_W-1:0] degree);
        t_pending entry;

        entry.hold = 1'b0;
        entry.req  = '{op: op, coefficient: coef, degree: degree};
        pending_requests.push_back(entry);
    endtask

    task automatic push_hold();
        t_pending entry;

        entry.hold = 1'b1;
        entry.req  = '0;
        pending_requests.push_back(entry);
    endtask

    // Waits until the sender has nothing left and every term is back, then
    // lets the block settle. Checks are made on the falling edge so that the
    // sender's updates at the rising edge have all landed.
    task automatic wait_until_idle();
        do @(negedge i_clk);
        while (pending_requests.size() > 0 || i_in_valid || expected_terms.size() > 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Register write: a setup phase, then an access phase held until pready.
    task automatic write_register(input t_reg_idx idx, input logic [PDATA_W-1:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == REG_OPERATION_MODE) begin
            mode_mirror = value[0];
        end
    endtask

    // Coefficients lean towards the extremes, where wrapping shows up.
    function automatic logic [31:0] pick_coef();
        case ($urandom_range(0, 9))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return 32'h0000_0000;
            3:       return 32'hFFFF_FFFF;
            4:       return 32'h0000_0001;
            default: return $urandom;
        endcase
    endfunction

    // One polynomial pair followed by a finish. Most pairs are small; one
    // pair fills every degree of both stores to give the longest result.
    task automatic queue_polynomial_pair();
        int n_first;
        int n_second;
        int last_degree;
        logic [1:0] op;
        logic [IN_DEG_W-1:0] degree;

        if (!full_done && mode_mirror) begin
            full_done = 1'b1;
            for (int d = 0; d < STORE_DEPTH; d++) begin
                push_request(OP_LOAD_FIRST, pick_coef(), d[IN_DEG_W-1:0]);
                push_request(OP_LOAD_SECOND, pick_coef(), d[IN_DEG_W-1:0]);
            end
            random_requests += 2 * STORE_DEPTH;
        end else begin
            n_first  = $urandom_range(0, 6);
            n_second = $urandom_range(0, 6);
            last_degree = $urandom_range(0, MAX_DEGREE_DEF);
            while (n_first + n_second > 0) begin
                if (n_second == 0 || (n_first > 0 && $urandom_range(0, 1) == 0)) begin
                    op = OP_LOAD_FIRST;
                    n_first--;
                end else begin
                    op = OP_LOAD_SECOND;
                    n_second--;
                end
                // Now and then a degree is loaded again, replacing its term.
                if ($urandom_range(0, 5) == 0) begin
                    degree = last_degree[IN_DEG_W-1:0];
                end else begin
                    degree = IN_DEG_W'($urandom_range(0, MAX_DEGREE_DEF));
                end
                last_degree = int'(degree);
                push_request(op, pick_coef(), degree);
                random_requests++;
                if ($urandom_range(0, 11) == 0) begin
                    push_request(OP_UNUSED, $urandom,
                                 IN_DEG_W'($urandom_range(0, MAX_DEGREE_DEF)));
                end
            end
        end
        push_request(OP_FINISH, $urandom, IN_DEG_W'($urandom_range(0, MAX_DEGREE_DEF)));
        random_requests++;
        if ($urandom_range(0, 3) == 0) begin
            push_hold();
        end
    endtask

    initial begin
        int phase;

        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in        = '0;
        i_out_ready = 1'b0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        mode_mirror = 1'b0;
        mismatches  = 0;
        random_requests = 0;
        in_gap      = 0;
        out_stall   = 0;
        quiet       = 1'b0;
        full_done   = 1'b0;
        for (int i = 0; i < STORE_DEPTH; i++) begin
            first_coef[i]     = '0;
            first_present[i]  = 1'b0;
            second_coef[i]    = '0;
            second_present[i] = 1'b0;
        end

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part, addition first: an empty finish, wrap at the top
        // degree, cancellation to zero, a replaced term and an ignored code.
        write_register(REG_OPERATION_MODE, 32'd0);
        push_request(OP_FINISH, 32'd0, 5'd0);
        push_request(OP_LOAD_FIRST, 32'h7FFF_FFFF, 5'd31);
        push_request(OP_LOAD_SECOND, 32'h0000_0001, 5'd31);
        push_request(OP_LOAD_FIRST, 32'h8000_0000, 5'd0);
        push_request(OP_LOAD_SECOND, 32'h8000_0000, 5'd0);
        push_request(OP_LOAD_FIRST, 32'd7, 5'd5);
        push_request(OP_LOAD_FIRST, 32'hFFFF_FFF9, 5'd5);
        push_request(OP_LOAD_SECOND, 32'd7, 5'd5);
        push_request(OP_UNUSED, 32'hFFFF_FFFF, 5'd31);
        push_request(OP_FINISH, 32'hFFFF_FFFF, 5'd31);
        push_hold();
        wait_until_idle();

        // Multiplication: the highest product degree, wrapping products, a
        // finish with only one operand and a finish with none.
        write_register(REG_OPERATION_MODE, 32'd1);
        push_request(OP_LOAD_FIRST, 32'hFFFF_FFFF, 5'd31);
        push_request(OP_LOAD_FIRST, 32'h7FFF_FFFF, 5'd0);
        push_request(OP_LOAD_SECOND, 32'h7FFF_FFFF, 5'd31);
        push_request(OP_LOAD_SECOND, 32'h8000_0000, 5'd0);
        push_request(OP_FINISH, 32'd0, 5'd0);
        push_request(OP_LOAD_FIRST, 32'd5, 5'd3);
        push_request(OP_FINISH, 32'd0, 5'd0);
        push_request(OP_FINISH, 32'd0, 5'd0);
        // Terms loaded under one mode survive a change of mode.
        push_request(OP_LOAD_FIRST, 32'd3, 5'd10);
        push_request(OP_LOAD_SECOND, 32'd4, 5'd10);
        wait_until_idle();
        write_register(REG_OPERATION_MODE, 32'd0);
        push_request(OP_FINISH, 32'd0, 5'd0);
        wait_until_idle();

        // Random part: phases of one to three polynomial pairs, the mode
        // alternating between phases. The final phases run without stalls.
        phase = $urandom_range(0, 1);
        while (random_requests < RANDOM_REQUESTS) begin
            if (random_requests >= RANDOM_REQUESTS - 40) begin
                quiet = 1'b1;
            end
            write_register(REG_OPERATION_MODE, PDATA_W'(phase[0]));
            repeat ($urandom_range(1, 3)) begin
                queue_polynomial_pair();
            end
            wait_until_idle();
            phase++;
        end

        if (mismatches == 0) begin
            $display("sparse_polynomial_add_multiply test passed");
        end else begin
            $display("sparse_polynomial_add_multiply test failed");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("sparse_polynomial_add_multiply test failed");
        $finish;
    end

endmodule

>>> sparse_polynomial_add_multiply.f
hw/rtl/spm_pkg.sv
hw/rtl/spm_cell.sv
hw/rtl/spm_feed.sv
hw/rtl/sparse_polynomial_add_multiply.sv
tb/sparse_polynomial_add_multiply_tb.sv
